// File: hdl/chstc_pkg.sv
// shared types and constants for the camera head search and track control
// no dependencies; used by the top level and its checker

package chstc_pkg;

    // default fraction bits of the angle fields (1/16 degree)
    localparam int ANGLE_FRAC_BITS_DEF = 4;

    localparam int ANGLE_W = 13;
    localparam int RATE_W  = 10;
    localparam int MODE_W  = 3;

    // rates in whole degrees per second
    localparam int SEARCH_RATE = 350;
    localparam int TILT_RATE   = 100;
    localparam int TRACK_RATE  = 200;

    // decision limits
    localparam int FLAG_LOST_LIMIT_MS = 2000;
    localparam int RECENT_LIMIT       = 10;
    localparam int LONG_AGO           = 100;
    localparam int NO_GOAL_LIMIT      = 50;
    localparam int NO_GOAL_MAX        = 255;
    localparam int MIN_FLAGS          = 2;

    // angle limits in whole degrees
    localparam int SWEEP_PAN_LIMIT_DEG = 115;
    localparam int BALL_TILT_HI_DEG    = -30;
    localparam int BALL_TILT_LO_DEG    = -40;
    localparam int FLAG_TILT_HI_DEG    = 5;
    localparam int FLAG_TILT_LO_DEG    = -5;
    localparam int TRACK_PAN_DEG       = 10;
    localparam int TRACK_TILT_HI_DEG   = -30;
    localparam int TRACK_TILT_LO_DEG   = -50;

    typedef enum logic [MODE_W-1:0] {
        MODE_HOLD        = 3'd0,
        MODE_SWEEP_BALL  = 3'd1,
        MODE_TRACK_BALL  = 3'd2,
        MODE_SWEEP_FLAGS = 3'd3,
        MODE_ATTACK      = 3'd4,
        MODE_AUTO        = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_HOLD        = 3'd0,
        ST_AFTER_LOSS  = 3'd1,
        ST_SWEEP_BALL  = 3'd2,
        ST_TRACK       = 3'd3,
        ST_SWEEP_FLAGS = 3'd4
    } strategy_t;

endpackage

// File: hdl/camera_head_search_track_control.sv
// camera head search and track control: one decision and rate pair per tick
// depends on chstc_pkg
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+---------------------------
//  item     | item_valid/item_ready, see_ball .. sweep  | perception tick in
//  result   | result_valid/result_ready, pan, tilt, st  | rate command out
//  cfg      | cfg_valid/cfg_ready, cfg_data             | mode register write
//
// an item is captured in the input register, then decided and written to the result
// register, and a new item can be taken every cycle while the result is not stalled
// the recency counters update as an item moves into the result register
// a stalled result holds both stages; cfg_ready is always high
// reset clears both valid flags and the counters and sets mode to automatic

module camera_head_search_track_control #(
    parameter int ANGLE_FRAC_BITS = chstc_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [chstc_pkg::MODE_W-1:0]           cfg_data,

    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  logic                                   see_ball,
    input  logic [3:0]                             flags_seen,
    input  logic                                   see_goal,
    input  logic [15:0]                            flag_lost_ms,
    input  logic signed [chstc_pkg::ANGLE_W-1:0]   ball_pan_angle,
    input  logic signed [chstc_pkg::ANGLE_W-1:0]   ball_tilt_angle,
    input  logic signed [chstc_pkg::ANGLE_W-1:0]   head_pan_angle,
    input  logic signed [chstc_pkg::ANGLE_W-1:0]   head_tilt_angle,
    input  logic                                   sweep_left_last,

    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [chstc_pkg::RATE_W-1:0]    pan_rate,
    output logic signed [chstc_pkg::RATE_W-1:0]    tilt_rate,
    output logic [2:0]                             strategy
);

    localparam int SCALE = 1 << ANGLE_FRAC_BITS;

    localparam int PAN_HI        = chstc_pkg::SWEEP_PAN_LIMIT_DEG * SCALE;
    localparam int PAN_LO        = -chstc_pkg::SWEEP_PAN_LIMIT_DEG * SCALE;
    localparam int BALL_TILT_HI  = chstc_pkg::BALL_TILT_HI_DEG * SCALE;
    localparam int BALL_TILT_LO  = chstc_pkg::BALL_TILT_LO_DEG * SCALE;
    localparam int FLAG_TILT_HI  = chstc_pkg::FLAG_TILT_HI_DEG * SCALE;
    localparam int FLAG_TILT_LO  = chstc_pkg::FLAG_TILT_LO_DEG * SCALE;
    localparam int TRK_PAN_HI    = chstc_pkg::TRACK_PAN_DEG * SCALE;
    localparam int TRK_PAN_LO    = -chstc_pkg::TRACK_PAN_DEG * SCALE;
    localparam int TRK_TILT_HI   = chstc_pkg::TRACK_TILT_HI_DEG * SCALE;
    localparam int TRK_TILT_LO   = chstc_pkg::TRACK_TILT_LO_DEG * SCALE;

    localparam logic signed [chstc_pkg::RATE_W-1:0] R_SEARCH_P =
        chstc_pkg::RATE_W'(chstc_pkg::SEARCH_RATE);
    localparam logic signed [chstc_pkg::RATE_W-1:0] R_SEARCH_N =
        chstc_pkg::RATE_W'(-chstc_pkg::SEARCH_RATE);
    localparam logic signed [chstc_pkg::RATE_W-1:0] R_TILT_P =
        chstc_pkg::RATE_W'(chstc_pkg::TILT_RATE);
    localparam logic signed [chstc_pkg::RATE_W-1:0] R_TILT_N =
        chstc_pkg::RATE_W'(-chstc_pkg::TILT_RATE);
    localparam logic signed [chstc_pkg::RATE_W-1:0] R_TRACK_P =
        chstc_pkg::RATE_W'(chstc_pkg::TRACK_RATE);
    localparam logic signed [chstc_pkg::RATE_W-1:0] R_TRACK_N =
        chstc_pkg::RATE_W'(-chstc_pkg::TRACK_RATE);
    localparam logic signed [chstc_pkg::RATE_W-1:0] R_ZERO = '0;

    // control state
    logic [chstc_pkg::MODE_W-1:0] mode_reg;
    logic                         in_valid_reg;
    logic                         out_valid_reg;
    logic [6:0]                   auto_recent_count_reg, auto_recent_count_next;
    logic [3:0]                   attack_recent_count_reg, attack_recent_count_next;
    logic [7:0]                   attack_no_goal_count_reg, attack_no_goal_count_next;

    // input stage payload
    logic                                 see_ball_reg;
    logic [3:0]                           flags_seen_reg;
    logic                                 see_goal_reg;
    logic [15:0]                          flag_lost_ms_reg;
    logic signed [chstc_pkg::ANGLE_W-1:0] ball_pan_reg;
    logic signed [chstc_pkg::ANGLE_W-1:0] ball_tilt_reg;
    logic signed [chstc_pkg::ANGLE_W-1:0] head_pan_reg;
    logic signed [chstc_pkg::ANGLE_W-1:0] head_tilt_reg;
    logic                                 sweep_left_reg;

    // result stage payload
    logic signed [chstc_pkg::RATE_W-1:0] pan_rate_reg, pan_rate_next;
    logic signed [chstc_pkg::RATE_W-1:0] tilt_rate_reg, tilt_rate_next;
    chstc_pkg::strategy_t                strategy_reg, strategy_next;

    logic       advance;
    logic       take_item;
    logic [7:0] no_goal_bumped;
    int         bp, bt, hp, ht, tilt_hi, tilt_lo;

    assign advance    = !out_valid_reg || result_ready;
    assign take_item  = in_valid_reg && advance;
    assign item_ready = !in_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign result_valid = out_valid_reg;
    assign pan_rate     = pan_rate_reg;
    assign tilt_rate    = tilt_rate_reg;
    assign strategy     = strategy_reg;

    assign no_goal_bumped = (attack_no_goal_count_reg == 8'(chstc_pkg::NO_GOAL_MAX)) ?
                            attack_no_goal_count_reg : attack_no_goal_count_reg + 8'd1;

    // strategy choice and counter updates
    always_comb
    begin
        auto_recent_count_next    = auto_recent_count_reg;
        attack_recent_count_next  = attack_recent_count_reg;
        attack_no_goal_count_next = attack_no_goal_count_reg;
        strategy_next             = chstc_pkg::ST_HOLD;
        unique case (mode_reg)
            chstc_pkg::MODE_HOLD:        strategy_next = chstc_pkg::ST_HOLD;
            chstc_pkg::MODE_SWEEP_BALL:  strategy_next = chstc_pkg::ST_SWEEP_BALL;
            chstc_pkg::MODE_TRACK_BALL:  strategy_next = chstc_pkg::ST_TRACK;
            chstc_pkg::MODE_SWEEP_FLAGS: strategy_next = chstc_pkg::ST_SWEEP_FLAGS;
            chstc_pkg::MODE_ATTACK:
            begin
                priority if (see_ball_reg && see_goal_reg)
                begin
                    attack_recent_count_next  = '0;
                    attack_no_goal_count_next = '0;
                    strategy_next             = chstc_pkg::ST_HOLD;
                end
                else if (!see_ball_reg &&
                         attack_recent_count_reg < 4'(chstc_pkg::RECENT_LIMIT))
                begin
                    attack_recent_count_next  = attack_recent_count_reg + 4'd1;
                    attack_no_goal_count_next = see_goal_reg ? 8'd0 : no_goal_bumped;
                    strategy_next             = chstc_pkg::ST_AFTER_LOSS;
                end
                else if (!see_ball_reg && see_goal_reg)
                begin
                    attack_no_goal_count_next = '0;
                    strategy_next             = chstc_pkg::ST_SWEEP_BALL;
                end
                else
                begin
                    // decision looks at the count after this tick's bump
                    attack_no_goal_count_next = no_goal_bumped;
                    if (see_ball_reg && no_goal_bumped < 8'(chstc_pkg::NO_GOAL_LIMIT))
                        strategy_next = chstc_pkg::ST_TRACK;
                    else
                        strategy_next = chstc_pkg::ST_SWEEP_FLAGS;
                end
            end
            default:
            begin
                // automatic, also for the unused mode codes
                priority if (see_ball_reg && flags_seen_reg >= 4'(chstc_pkg::MIN_FLAGS))
                begin
                    auto_recent_count_next = '0;
                    strategy_next          = chstc_pkg::ST_HOLD;
                end
                else if (!see_ball_reg &&
                         auto_recent_count_reg < 7'(chstc_pkg::RECENT_LIMIT))
                begin
                    auto_recent_count_next = auto_recent_count_reg + 7'd1;
                    strategy_next          = chstc_pkg::ST_AFTER_LOSS;
                end
                else
                begin
                    auto_recent_count_next = 7'(chstc_pkg::LONG_AGO);
                    if (!see_ball_reg)
                        strategy_next = chstc_pkg::ST_SWEEP_BALL;
                    else if (flag_lost_ms_reg < 16'(chstc_pkg::FLAG_LOST_LIMIT_MS))
                        strategy_next = chstc_pkg::ST_TRACK;
                    else
                        strategy_next = chstc_pkg::ST_SWEEP_FLAGS;
                end
            end
        endcase
    end

    // rates for the chosen behavior
    always_comb
    begin
        bp = int'(ball_pan_reg);
        bt = int'(ball_tilt_reg);
        hp = int'(head_pan_reg);
        ht = int'(head_tilt_reg);
        tilt_hi = (strategy_next == chstc_pkg::ST_SWEEP_BALL) ? BALL_TILT_HI : FLAG_TILT_HI;
        tilt_lo = (strategy_next == chstc_pkg::ST_SWEEP_BALL) ? BALL_TILT_LO : FLAG_TILT_LO;
        pan_rate_next  = R_ZERO;
        tilt_rate_next = R_ZERO;
        unique case (strategy_next)
            chstc_pkg::ST_AFTER_LOSS:
            begin
                pan_rate_next  = (bp < 0) ? R_SEARCH_N : R_SEARCH_P;
                tilt_rate_next = (bt < 0) ? R_SEARCH_N : R_SEARCH_P;
            end
            chstc_pkg::ST_SWEEP_BALL, chstc_pkg::ST_SWEEP_FLAGS:
            begin
                priority if (hp >= PAN_HI)
                    pan_rate_next = R_SEARCH_N;
                else if (hp <= PAN_LO)
                    pan_rate_next = R_SEARCH_P;
                else
                    pan_rate_next = sweep_left_reg ? R_SEARCH_P : R_SEARCH_N;
                priority if (ht > tilt_hi)
                    tilt_rate_next = R_TILT_N;
                else if (ht < tilt_lo)
                    tilt_rate_next = R_TILT_P;
                else
                    tilt_rate_next = R_ZERO;
            end
            chstc_pkg::ST_TRACK:
            begin
                priority if (bp > TRK_PAN_HI)
                    pan_rate_next = R_TRACK_P;
                else if (bp < TRK_PAN_LO)
                    pan_rate_next = R_TRACK_N;
                else
                    pan_rate_next = R_ZERO;
                priority if (bt > TRK_TILT_HI)
                    tilt_rate_next = R_TRACK_P;
                else if (bt < TRK_TILT_LO)
                    tilt_rate_next = R_TRACK_N;
                else
                    tilt_rate_next = R_ZERO;
            end
            default:
            begin
                pan_rate_next  = R_ZERO;
                tilt_rate_next = R_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg                 <= chstc_pkg::MODE_AUTO;
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            auto_recent_count_reg    <= '0;
            attack_recent_count_reg  <= '0;
            attack_no_goal_count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            if (item_ready)
                in_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (take_item)
            begin
                auto_recent_count_reg    <= auto_recent_count_next;
                attack_recent_count_reg  <= attack_recent_count_next;
                attack_no_goal_count_reg <= attack_no_goal_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            see_ball_reg     <= see_ball;
            flags_seen_reg   <= flags_seen;
            see_goal_reg     <= see_goal;
            flag_lost_ms_reg <= flag_lost_ms;
            ball_pan_reg     <= ball_pan_angle;
            ball_tilt_reg    <= ball_tilt_angle;
            head_pan_reg     <= head_pan_angle;
            head_tilt_reg    <= head_tilt_angle;
            sweep_left_reg   <= sweep_left_last;
        end
        if (take_item)
        begin
            pan_rate_reg  <= pan_rate_next;
            tilt_rate_reg <= tilt_rate_next;
            strategy_reg  <= strategy_next;
        end
    end

endmodule

// File: hdl/chstc_checker.sv
// port level checks for camera_head_search_track_control, bound to the top level
// depends on chstc_pkg

module chstc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic signed [chstc_pkg::RATE_W-1:0]  pan_rate,
    input logic signed [chstc_pkg::RATE_W-1:0]  tilt_rate,
    input logic [2:0]                           strategy
);

    // a stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(pan_rate) &&
        $stable(tilt_rate) && $stable(strategy))
        else $error("result changed while stalled");

    a_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && strategy == chstc_pkg::ST_HOLD |-> pan_rate == 0 && tilt_rate == 0)
        else $error("hold with nonzero rate");

    a_after_loss_rates: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && strategy == chstc_pkg::ST_AFTER_LOSS |->
        (pan_rate == chstc_pkg::SEARCH_RATE || pan_rate == -chstc_pkg::SEARCH_RATE) &&
        (tilt_rate == chstc_pkg::SEARCH_RATE || tilt_rate == -chstc_pkg::SEARCH_RATE))
        else $error("search after loss without full rates");

    // sweeps always pan at full rate, tilt at most the slow rate
    a_sweep_rates: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (strategy == chstc_pkg::ST_SWEEP_BALL ||
        strategy == chstc_pkg::ST_SWEEP_FLAGS) |->
        (pan_rate == chstc_pkg::SEARCH_RATE || pan_rate == -chstc_pkg::SEARCH_RATE) &&
        (tilt_rate == chstc_pkg::TILT_RATE || tilt_rate == -chstc_pkg::TILT_RATE ||
        tilt_rate == 0))
        else $error("sweep with bad rates");

    a_track_rates: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && strategy == chstc_pkg::ST_TRACK |->
        (pan_rate == chstc_pkg::TRACK_RATE || pan_rate == -chstc_pkg::TRACK_RATE ||
        pan_rate == 0) &&
        (tilt_rate == chstc_pkg::TRACK_RATE || tilt_rate == -chstc_pkg::TRACK_RATE ||
        tilt_rate == 0))
        else $error("track with bad rates");

endmodule

bind camera_head_search_track_control chstc_checker u_chstc_checker (.*);

// File: bench/testbench.sv
// self-checking bench for camera_head_search_track_control: directed ticks per mode,
// then random tick sequences with mode changes, each rate command checked in order
// depends on chstc_pkg and the camera_head_search_track_control top level

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = chstc_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_TICKS = 1600;
    localparam int MAX_PRINTED  = 40;

    // mode values with no behavior of their own, they act as automatic
    localparam logic [chstc_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [chstc_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

    typedef struct {
        logic                                 see_ball;
        logic [3:0]                           flags_seen;
        logic                                 see_goal;
        logic [15:0]                          flag_lost_ms;
        logic signed [chstc_pkg::ANGLE_W-1:0] ball_pan;
        logic signed [chstc_pkg::ANGLE_W-1:0] ball_tilt;
        logic signed [chstc_pkg::ANGLE_W-1:0] head_pan;
        logic signed [chstc_pkg::ANGLE_W-1:0] head_tilt;
        logic                                 sweep_left;
    } tick_t;

    typedef struct {
        logic signed [chstc_pkg::RATE_W-1:0] pan;
        logic signed [chstc_pkg::RATE_W-1:0] tilt;
        chstc_pkg::strategy_t                behavior;
    } rate_cmd_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [chstc_pkg::MODE_W-1:0]         cfg_data;
    logic                                 item_valid;
    logic                                 item_ready;
    logic                                 see_ball;
    logic [3:0]                           flags_seen;
    logic                                 see_goal;
    logic [15:0]                          flag_lost_ms;
    logic signed [chstc_pkg::ANGLE_W-1:0] ball_pan_angle;
    logic signed [chstc_pkg::ANGLE_W-1:0] ball_tilt_angle;
    logic signed [chstc_pkg::ANGLE_W-1:0] head_pan_angle;
    logic signed [chstc_pkg::ANGLE_W-1:0] head_tilt_angle;
    logic                                 sweep_left_last;
    logic                                 result_valid;
    logic                                 result_ready;
    logic signed [chstc_pkg::RATE_W-1:0]  pan_rate;
    logic signed [chstc_pkg::RATE_W-1:0]  tilt_rate;
    logic [2:0]                           strategy;

    // mirror of the mode register and the recency counters
    logic [chstc_pkg::MODE_W-1:0] model_mode;
    logic [6:0]                   auto_recent;
    logic [3:0]                   attack_recent;
    logic [7:0]                   no_goal_count;

    rate_cmd_t pending_cmds[$];
    int        error_count  = 0;
    int        cycle_count  = 0;
    int        random_ticks = 0;
    int        sender_calm  = 0;

    camera_head_search_track_control dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .see_ball        (see_ball),
        .flags_seen      (flags_seen),
        .see_goal        (see_goal),
        .flag_lost_ms    (flag_lost_ms),
        .ball_pan_angle  (ball_pan_angle),
        .ball_tilt_angle (ball_tilt_angle),
        .head_pan_angle  (head_pan_angle),
        .head_tilt_angle (head_tilt_angle),
        .sweep_left_last (sweep_left_last),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .pan_rate        (pan_rate),
        .tilt_rate       (tilt_rate),
        .strategy        (strategy)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int deg(input int d);
        return d * (1 << FRAC_BITS);
    endfunction

    function automatic logic signed [chstc_pkg::RATE_W-1:0] rate(input int r);
        return chstc_pkg::RATE_W'(r);
    endfunction

    function automatic rate_cmd_t rates_for(input chstc_pkg::strategy_t s, input tick_t t);
        rate_cmd_t c;
        int        hi_lim;
        int        lo_lim;
        c.pan = '0;
        c.tilt = '0;
        c.behavior = s;
        case (s)
            chstc_pkg::ST_AFTER_LOSS:
            begin
                c.pan  = rate((t.ball_pan < 0) ? -chstc_pkg::SEARCH_RATE
                                               : chstc_pkg::SEARCH_RATE);
                c.tilt = rate((t.ball_tilt < 0) ? -chstc_pkg::SEARCH_RATE
                                                : chstc_pkg::SEARCH_RATE);
            end
            chstc_pkg::ST_SWEEP_BALL, chstc_pkg::ST_SWEEP_FLAGS:
            begin
                hi_lim = (s == chstc_pkg::ST_SWEEP_BALL) ? deg(chstc_pkg::BALL_TILT_HI_DEG)
                                                         : deg(chstc_pkg::FLAG_TILT_HI_DEG);
                lo_lim = (s == chstc_pkg::ST_SWEEP_BALL) ? deg(chstc_pkg::BALL_TILT_LO_DEG)
                                                         : deg(chstc_pkg::FLAG_TILT_LO_DEG);
                if (t.head_pan >= deg(chstc_pkg::SWEEP_PAN_LIMIT_DEG))
                    c.pan = rate(-chstc_pkg::SEARCH_RATE);
                else if (t.head_pan <= -deg(chstc_pkg::SWEEP_PAN_LIMIT_DEG))
                    c.pan = rate(chstc_pkg::SEARCH_RATE);
                else
                    c.pan = rate(t.sweep_left ? chstc_pkg::SEARCH_RATE
                                              : -chstc_pkg::SEARCH_RATE);
                if (t.head_tilt > hi_lim)
                    c.tilt = rate(-chstc_pkg::TILT_RATE);
                else if (t.head_tilt < lo_lim)
                    c.tilt = rate(chstc_pkg::TILT_RATE);
            end
            chstc_pkg::ST_TRACK:
            begin
                if (t.ball_pan > deg(chstc_pkg::TRACK_PAN_DEG))
                    c.pan = rate(chstc_pkg::TRACK_RATE);
                else if (t.ball_pan < -deg(chstc_pkg::TRACK_PAN_DEG))
                    c.pan = rate(-chstc_pkg::TRACK_RATE);
                if (t.ball_tilt > deg(chstc_pkg::TRACK_TILT_HI_DEG))
                    c.tilt = rate(chstc_pkg::TRACK_RATE);
                else if (t.ball_tilt < deg(chstc_pkg::TRACK_TILT_LO_DEG))
                    c.tilt = rate(-chstc_pkg::TRACK_RATE);
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic chstc_pkg::strategy_t pick_automatic(input tick_t t);
        if (t.see_ball && t.flags_seen >= chstc_pkg::MIN_FLAGS)
        begin
            auto_recent = '0;
            return chstc_pkg::ST_HOLD;
        end
        if (!t.see_ball && auto_recent < chstc_pkg::RECENT_LIMIT)
        begin
            auto_recent++;
            return chstc_pkg::ST_AFTER_LOSS;
        end
        auto_recent = 7'(chstc_pkg::LONG_AGO);
        if (!t.see_ball)
            return chstc_pkg::ST_SWEEP_BALL;
        return (t.flag_lost_ms < chstc_pkg::FLAG_LOST_LIMIT_MS) ? chstc_pkg::ST_TRACK
                                                               : chstc_pkg::ST_SWEEP_FLAGS;
    endfunction

    function automatic chstc_pkg::strategy_t pick_attacking(input tick_t t);
        if (t.see_ball && t.see_goal)
        begin
            attack_recent = '0;
            no_goal_count = '0;
            return chstc_pkg::ST_HOLD;
        end
        if (!t.see_ball && attack_recent < chstc_pkg::RECENT_LIMIT)
        begin
            attack_recent++;
            if (t.see_goal)
                no_goal_count = '0;
            else if (no_goal_count < chstc_pkg::NO_GOAL_MAX)
                no_goal_count++;
            return chstc_pkg::ST_AFTER_LOSS;
        end
        if (!t.see_ball && t.see_goal)
        begin
            no_goal_count = '0;
            return chstc_pkg::ST_SWEEP_BALL;
        end
        if (no_goal_count < chstc_pkg::NO_GOAL_MAX)
            no_goal_count++;
        return (t.see_ball && no_goal_count < chstc_pkg::NO_GOAL_LIMIT) ?
               chstc_pkg::ST_TRACK : chstc_pkg::ST_SWEEP_FLAGS;
    endfunction

    function automatic rate_cmd_t head_command(input tick_t t);
        chstc_pkg::strategy_t s;
        case (model_mode)
            chstc_pkg::MODE_HOLD:        s = chstc_pkg::ST_HOLD;
            chstc_pkg::MODE_SWEEP_BALL:  s = chstc_pkg::ST_SWEEP_BALL;
            chstc_pkg::MODE_TRACK_BALL:  s = chstc_pkg::ST_TRACK;
            chstc_pkg::MODE_SWEEP_FLAGS: s = chstc_pkg::ST_SWEEP_FLAGS;
            chstc_pkg::MODE_ATTACK:      s = pick_attacking(t);
            default:                     s = pick_automatic(t);
        endcase
        return rates_for(s, t);
    endfunction

    function automatic tick_t make_tick(input bit ball, input int flags, input bit goal,
                                        input int lost, input int bp, input int bt,
                                        input int hp, input int ht, input bit left);
        tick_t t;
        t.see_ball = ball;
        t.flags_seen = 4'(flags);
        t.see_goal = goal;
        t.flag_lost_ms = 16'(lost);
        t.ball_pan = chstc_pkg::ANGLE_W'(bp);
        t.ball_tilt = chstc_pkg::ANGLE_W'(bt);
        t.head_pan = chstc_pkg::ANGLE_W'(hp);
        t.head_tilt = chstc_pkg::ANGLE_W'(ht);
        t.sweep_left = left;
        return t;
    endfunction

    // a quarter of the angles land right on a decision limit or on zero, or one step off it
    function automatic logic signed [chstc_pkg::ANGLE_W-1:0] rand_angle();
        int mark;
        if ($urandom_range(0, 3) != 0)
            return chstc_pkg::ANGLE_W'(int'($urandom_range(0, 5760)) - 2880);
        case ($urandom_range(0, 9))
            0:       mark = deg(chstc_pkg::SWEEP_PAN_LIMIT_DEG);
            1:       mark = -deg(chstc_pkg::SWEEP_PAN_LIMIT_DEG);
            2:       mark = deg(chstc_pkg::BALL_TILT_HI_DEG);
            3:       mark = deg(chstc_pkg::BALL_TILT_LO_DEG);
            4:       mark = deg(chstc_pkg::FLAG_TILT_HI_DEG);
            5:       mark = deg(chstc_pkg::FLAG_TILT_LO_DEG);
            6:       mark = deg(chstc_pkg::TRACK_PAN_DEG);
            7:       mark = -deg(chstc_pkg::TRACK_PAN_DEG);
            8:       mark = deg(chstc_pkg::TRACK_TILT_LO_DEG);
            default: mark = 0;
        endcase
        return chstc_pkg::ANGLE_W'(mark + int'($urandom_range(0, 2)) - 1);
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        int    r;
        t.see_ball = 1'($urandom_range(0, 1));
        t.flags_seen = 4'($urandom_range(0, 15));
        t.see_goal = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 3);
        if (r < 2)
            t.flag_lost_ms = 16'($urandom_range(chstc_pkg::FLAG_LOST_LIMIT_MS - 8,
                                                chstc_pkg::FLAG_LOST_LIMIT_MS + 8));
        else if (r == 2)
            t.flag_lost_ms = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else
            t.flag_lost_ms = 16'($urandom_range(0, 65535));
        t.ball_pan = rand_angle();
        t.ball_tilt = rand_angle();
        t.head_pan = rand_angle();
        t.head_tilt = rand_angle();
        t.sweep_left = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic drive_payload(input tick_t t);
        see_ball <= t.see_ball;
        flags_seen <= t.flags_seen;
        see_goal <= t.see_goal;
        flag_lost_ms <= t.flag_lost_ms;
        ball_pan_angle <= t.ball_pan;
        ball_tilt_angle <= t.ball_tilt;
        head_pan_angle <= t.head_pan;
        head_tilt_angle <= t.head_tilt;
        sweep_left_last <= t.sweep_left;
    endtask

    // valid stays high into the next call when no pause is drawn
    task automatic send_tick(input tick_t t);
        int gap;
        item_valid <= 1'b1;
        drive_payload(t);
        do @(posedge clk); while (!item_ready);
        pending_cmds.push_back(head_command(t));
        gap = 0;
        if (sender_calm > 0)
            sender_calm--;
        else if ($urandom_range(0, 99) < 3)
            sender_calm = $urandom_range(30, 150);
        else if ($urandom_range(0, 99) < 35)
            gap = rand_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mode changes only once every command in flight has come out
    task automatic write_mode(input logic [chstc_pkg::MODE_W-1:0] m);
        item_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_mode = m;
    endtask

    task automatic test_automatic_after_reset();
        // mode is still automatic from reset
        send_tick(make_tick(1, chstc_pkg::MIN_FLAGS, 0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 15, 0, 0, -2880, 2880, 0, 0, 0));
        send_tick(make_tick(0, 0, 1, 0, 0, -1, 0, 0, 1));
        send_tick(make_tick(1, 1, 0, chstc_pkg::FLAG_LOST_LIMIT_MS - 1, 2880, -2880,
                            0, 0, 0));
        send_tick(make_tick(0, chstc_pkg::MIN_FLAGS, 0, 0, 0, 0, 2880, 2880, 1));
        send_tick(make_tick(1, 0, 0, chstc_pkg::FLAG_LOST_LIMIT_MS, 0, 0, -2880, -2880, 0));
        send_tick(make_tick(1, 3, 1, 16'hFFFF, 0, 0, 0, 0, 1));
    endtask

    task automatic test_fixed_modes();
        write_mode(chstc_pkg::MODE_HOLD);
        send_tick(make_tick(1, 15, 1, 16'hFFFF, 2880, 2880, 2880, 2880, 1));
        write_mode(chstc_pkg::MODE_SWEEP_BALL);
        // pan on and just inside its limits, tilt on and just outside both edges of the dead band
        send_tick(make_tick(0, 0, 0, 0, 0, 0, deg(chstc_pkg::SWEEP_PAN_LIMIT_DEG),
                            deg(chstc_pkg::BALL_TILT_HI_DEG) + 1, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, -deg(chstc_pkg::SWEEP_PAN_LIMIT_DEG),
                            deg(chstc_pkg::BALL_TILT_LO_DEG) - 1, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, deg(chstc_pkg::SWEEP_PAN_LIMIT_DEG) - 1,
                            deg(chstc_pkg::BALL_TILT_HI_DEG), 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 1 - deg(chstc_pkg::SWEEP_PAN_LIMIT_DEG),
                            deg(chstc_pkg::BALL_TILT_LO_DEG), 1));
        write_mode(chstc_pkg::MODE_TRACK_BALL);
        send_tick(make_tick(1, 0, 0, 0, deg(chstc_pkg::TRACK_PAN_DEG) + 1,
                            deg(chstc_pkg::TRACK_TILT_HI_DEG) + 1, 0, 0, 0));
        send_tick(make_tick(1, 0, 0, 0, -deg(chstc_pkg::TRACK_PAN_DEG) - 1,
                            deg(chstc_pkg::TRACK_TILT_LO_DEG) - 1, 0, 0, 0));
        send_tick(make_tick(1, 0, 0, 0, deg(chstc_pkg::TRACK_PAN_DEG),
                            deg(chstc_pkg::TRACK_TILT_LO_DEG), 0, 0, 0));
        write_mode(chstc_pkg::MODE_SWEEP_FLAGS);
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 2880, deg(chstc_pkg::FLAG_TILT_HI_DEG) + 1, 1));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, -2880, deg(chstc_pkg::FLAG_TILT_LO_DEG) - 1, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, deg(chstc_pkg::FLAG_TILT_HI_DEG), 1));
    endtask

    task automatic test_attacking();
        write_mode(chstc_pkg::MODE_ATTACK);
        send_tick(make_tick(1, 0, 1, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, -1, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 1, 0, 0, -2880, 0, 0, 0));
        send_tick(make_tick(1, 15, 0, 0, 2880, 2880, 0, 0, 0));
        send_tick(make_tick(1, 0, 1, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_spare_modes();
        write_mode(MODE_SPARE_A);
        send_tick(make_tick(1, chstc_pkg::MIN_FLAGS, 0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
        write_mode(MODE_SPARE_B);
        send_tick(rand_tick());
    endtask

    // runs of episodes: both seen, ball lost, ball alone or fully random, and in
    // attacking mode now and then a run long enough to saturate the no-goal count
    task automatic run_phase(input logic [chstc_pkg::MODE_W-1:0] m, input int n_ticks);
        int    sent;
        int    run;
        int    kind;
        tick_t t;
        write_mode(m);
        sent = 0;
        while (sent < n_ticks)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
                run = $urandom_range(1, 4);
            else if (kind < 55)
                run = $urandom_range(1, 14);
            else if (kind < 80)
                run = $urandom_range(1, 12);
            else if (kind < 83 && m == chstc_pkg::MODE_ATTACK)
                run = $urandom_range(260, 300);
            else
                run = $urandom_range(1, 5);
            repeat (run)
            begin
                t = rand_tick();
                if (kind < 25)
                begin
                    t.see_ball = 1'b1;
                    t.see_goal = 1'b1;
                    t.flags_seen = 4'($urandom_range(chstc_pkg::MIN_FLAGS, 15));
                end
                else if (kind < 55)
                begin
                    t.see_ball = 1'b0;
                    t.see_goal = ($urandom_range(0, 9) < 3);
                end
                else if (kind < 83)
                begin
                    t.see_ball = 1'b1;
                    t.see_goal = 1'b0;
                    t.flags_seen = 4'($urandom_range(0, chstc_pkg::MIN_FLAGS - 1));
                end
                send_tick(t);
                sent++;
            end
        end
        random_ticks += sent;
    endtask

    task automatic test_random_traffic();
        int                           phase;
        int                           r;
        logic [chstc_pkg::MODE_W-1:0] m;
        phase = 0;
        while (random_ticks < RANDOM_TICKS)
        begin
            r = $urandom_range(0, 99);
            case (phase)
                0:       m = chstc_pkg::MODE_ATTACK;
                1:       m = chstc_pkg::MODE_HOLD;
                2:       m = chstc_pkg::MODE_AUTO;
                3:       m = chstc_pkg::MODE_SWEEP_BALL;
                4:       m = MODE_SPARE_B;
                5:       m = chstc_pkg::MODE_TRACK_BALL;
                6:       m = chstc_pkg::MODE_SWEEP_FLAGS;
                7:       m = MODE_SPARE_A;
                default:
                begin
                    if (r < 35)
                        m = chstc_pkg::MODE_ATTACK;
                    else if (r < 70)
                        m = chstc_pkg::MODE_AUTO;
                    else
                        m = chstc_pkg::MODE_W'($urandom_range(chstc_pkg::MODE_HOLD,
                                                              MODE_SPARE_B));
                end
            endcase
            run_phase(m, $urandom_range(40, 160));
            phase++;
        end
    endtask

    // result side backpressure, with quiet stretches of steady ready
    initial
    begin : result_backpressure
        int calm_left;
        int stall_left;
        int r;
        calm_left = 0;
        stall_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                result_ready <= 1'b0;
            else if (calm_left > 0)
            begin
                calm_left--;
                result_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm_left = $urandom_range(50, 200);
                else if (r < 18)
                    stall_left = rand_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        rate_cmd_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_cmds.size() == 0)
                report_mismatch("result transfer with no command expected");
            else
            begin
                want = pending_cmds.pop_front();
                if (pan_rate !== want.pan)
                    report_mismatch($sformatf("pan_rate %0d, expected %0d", pan_rate, want.pan));
                if (tilt_rate !== want.tilt)
                    report_mismatch($sformatf("tilt_rate %0d, expected %0d",
                                              tilt_rate, want.tilt));
                if (strategy !== want.behavior)
                    report_mismatch($sformatf("strategy %0d, expected %0d",
                                              strategy, want.behavior));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= chstc_pkg::MODE_AUTO;
        item_valid <= 1'b0;
        drive_payload(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));
        model_mode = chstc_pkg::MODE_AUTO;
        auto_recent = '0;
        attack_recent = '0;
        no_goal_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_automatic_after_reset();
        test_fixed_modes();
        test_attacking();
        test_spare_modes();
        test_random_traffic();

        item_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
